[hw/rtl/langtons_ant_grid_stepper_unit_defines.svh]
// Assertion macros shared by the Langton's ant grid stepper RTL.
// No dependencies; each user file supplies clk and rst_n in scope.
`ifndef LANGTONS_ANT_GRID_STEPPER_UNIT_DEFINES_SVH
`define LANGTONS_ANT_GRID_STEPPER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LANT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LANT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lant_pkg.sv]
// Shared types and constants for the Langton's ant grid stepper.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package lant_pkg;

  // Request kinds, carried on in_tuser
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    HD_UP    = 2'd0,
    HD_RIGHT = 2'd1,
    HD_DOWN  = 2'd2,
    HD_LEFT  = 2'd3
  } heading_t;

  localparam logic [1:0] CELL_OFF = 2'd0;
  localparam logic [1:0] CELL_ON  = 2'd1;
  localparam logic [1:0] CELL_ANT = 2'd2;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 1;
  localparam int POS_FIELD_W = 6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_RD_NEW,
    S_MARK,
    S_RESP
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clr_en;
    logic take;
    logic eval;
    logic rd_new;
    logic mark;
    logic load_out;
  } lant_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic ant_here;
  } lant_sts_t;

endpackage

`default_nettype wire

[hw/rtl/langtons_ant_grid_stepper_unit.sv]
// Top level of the Langton's ant grid stepper: toroidal grid with one ant.
// Depends on lant_pkg, lant_ctrl and lant_dp.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------------
//  in_     | in  | in_tvalid / in_tready | tdata row, col, cell_value; tuser action
//  out_    | out | out_tvalid/out_tready | tdata read_value, ant_row, ant_col,
//          |     |                       |   ant_heading; tuser placed
//
// Sequencing: one request at a time. Write, read and unused action are accepted,
//   then responded to; a step that places the ant reads, places it and responds;
//   a step that moves reads, restores the old cell, reads the new cell, marks it
//   and responds, phases set by the single port of the grid memory.
// Reset: rst_n low clears the ant state; afterwards a clearing pass writes all
//   2^(clog2(GRID_ROWS)+clog2(GRID_COLS)) grid entries (4096 at 64x64) to off,
//   with in_tready low throughout.
// Stalls: a finished result sits in the output register until taken; a new
//   request may be accepted meanwhile, and its result waits for the slot.
`default_nettype none

module langtons_ant_grid_stepper_unit
  import lant_pkg::*;
#(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [5:0] row, [11:6] col, [13:12] cell_value, [15:14] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [1:0] read_value, [7:2] ant_row, [13:8] ant_col, [15:14] ant_heading
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // [0] placed
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  lant_cmd_t cmd;
  lant_sts_t sts;

  // sequencer: clearing pass, step phases, output slot
  lant_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // grid memory, ant position/heading/saved cell, result register
  lant_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/lant_dp.sv]
// Datapath of the Langton's ant grid stepper: grid memory, ant registers, result register.
// Depends on lant_pkg and langtons_ant_grid_stepper_unit_defines.svh.
`default_nettype none
`include "langtons_ant_grid_stepper_unit_defines.svh"

module lant_dp
  import lant_pkg::*;
#(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  input  wire lant_cmd_t              cmd,
  output lant_sts_t                   sts,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);
  localparam logic [10:0]      ROW_LIM  = 11'(GRID_ROWS);
  localparam logic [10:0]      COL_LIM  = 11'(GRID_COLS);

  // grid memory, single port, registered read
  logic [1:0]        mem_r [DEPTH];
  logic [1:0]        mem_q_r;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [1:0]        mem_wdata;

  logic [ROW_W-1:0]  pos_row_r, pos_row_nxt;
  logic [COL_W-1:0]  pos_col_r, pos_col_nxt;
  logic [1:0]        heading_r, heading_nxt;
  logic [1:0]        under_r, under_nxt;
  logic              placed_r, placed_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  action_t           act_r;
  logic              inside_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  // input fields
  logic [POS_FIELD_W-1:0] in_row, in_col;
  logic [1:0]             in_val;
  action_t                in_act;
  logic                   in_inside;
  logic [ADDR_W-1:0]      in_addr, pos_addr;

  logic [1:0]        head_turn;
  logic              turn_left;
  logic              ant_here;
  logic [ROW_W-1:0]  row_dec, row_inc, mov_row;
  logic [COL_W-1:0]  col_dec, col_inc, mov_col;
  logic [1:0]        rd_val;

  assign in_row    = in_tdata[5:0];
  assign in_col    = in_tdata[11:6];
  assign in_val    = in_tdata[13:12];
  assign in_act    = action_t'(in_tuser);
  assign in_inside = (11'(in_row) < ROW_LIM) && (11'(in_col) < COL_LIM);
  assign in_addr   = {ROW_W'(in_row), COL_W'(in_col)};
  assign pos_addr  = {pos_row_r, pos_col_r};

  assign ant_here  = (mem_q_r == CELL_ANT);
  assign turn_left = (under_r == CELL_ON);
  assign head_turn = turn_left ? (heading_r - 2'd1) : (heading_r + 2'd1);

  // toroidal neighbors
  assign row_dec = (pos_row_r == '0) ? ROW_LAST : (pos_row_r - 1'b1);
  assign row_inc = (pos_row_r == ROW_LAST) ? '0 : (pos_row_r + 1'b1);
  assign col_dec = (pos_col_r == '0) ? COL_LAST : (pos_col_r - 1'b1);
  assign col_inc = (pos_col_r == COL_LAST) ? '0 : (pos_col_r + 1'b1);

  always_comb begin
    mov_row = pos_row_r;
    mov_col = pos_col_r;
    case (heading_t'(head_turn))
      HD_UP:    mov_row = row_dec;
      HD_RIGHT: mov_col = col_inc;
      HD_DOWN:  mov_row = row_inc;
      HD_LEFT:  mov_col = col_dec;
      default:  mov_row = pos_row_r;
    endcase
  end

  // memory port select
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pos_addr;
    mem_wdata = CELL_ANT;
    if (cmd.clr_en) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr_r;
      mem_wdata = CELL_OFF;
    end else if (cmd.take) begin
      mem_addr  = (in_act == ACT_STEP) ? pos_addr : in_addr;
      mem_we    = (in_act == ACT_WRITE) && in_inside;
      mem_re    = ((in_act == ACT_READ) && in_inside) || (in_act == ACT_STEP);
      mem_wdata = in_val;
    end else if (cmd.eval) begin
      // leaving cell gets on/off swapped; otherwise just place the ant
      mem_we    = 1'b1;
      mem_wdata = ant_here ? (turn_left ? CELL_OFF : CELL_ON) : CELL_ANT;
    end else if (cmd.rd_new) begin
      mem_re    = 1'b1;
    end else if (cmd.mark) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem_r[mem_addr];
    end
  end

  // ant state next values
  always_comb begin
    pos_row_nxt  = pos_row_r;
    pos_col_nxt  = pos_col_r;
    heading_nxt  = heading_r;
    under_nxt    = under_r;
    placed_nxt   = placed_r;
    clr_addr_nxt = cmd.clr_en ? (clr_addr_r + 1'b1) : clr_addr_r;
    if (cmd.take) begin
      placed_nxt = 1'b0;
    end else if (cmd.eval) begin
      if (ant_here) begin
        heading_nxt = head_turn;
        pos_row_nxt = mov_row;
        pos_col_nxt = mov_col;
      end else begin
        under_nxt  = mem_q_r;
        placed_nxt = 1'b1;
      end
    end else if (cmd.mark) begin
      under_nxt = mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_row_r  <= '0;
      pos_col_r  <= '0;
      heading_r  <= HD_UP;
      under_r    <= CELL_OFF;
      placed_r   <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      pos_row_r  <= pos_row_nxt;
      pos_col_r  <= pos_col_nxt;
      heading_r  <= heading_nxt;
      under_r    <= under_nxt;
      placed_r   <= placed_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // request info kept for the response
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_r    <= in_act;
      inside_r <= in_inside;
    end
  end

  assign rd_val = ((act_r == ACT_READ) && inside_r) ? mem_q_r : CELL_OFF;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata_r <= {heading_r, POS_FIELD_W'(pos_col_r), POS_FIELD_W'(pos_row_r), rd_val};
      out_tuser_r <= placed_r;
    end
  end

  assign out_tdata    = out_tdata_r;
  assign out_tuser    = out_tuser_r;
  assign sts.ant_here = ant_here;
  assign sts.clr_done = (clr_addr_r == '1);

  `LANT_ASSERT_NEXT(a_heading_hold, !cmd.eval, $stable(heading_r), "heading moved outside a step")
  `LANT_ASSERT_NEXT(a_place_flag, cmd.eval && !sts.ant_here, placed_r, "placement not flagged")
  `LANT_ASSERT_NEXT(a_take_clears, cmd.take, !placed_r, "stale placement flag")

endmodule

`default_nettype wire

[hw/rtl/lant_ctrl.sv]
// Controller of the Langton's ant grid stepper: sequencer and result-valid flag.
// Depends on lant_pkg and langtons_ant_grid_stepper_unit_defines.svh.
`default_nettype none
`include "langtons_ant_grid_stepper_unit_defines.svh"

module lant_ctrl
  import lant_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire lant_sts_t             sts,
  output lant_cmd_t                  cmd
);

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (action_t'(in_tuser) == ACT_STEP) ? S_EVAL : S_RESP;
        end
      end
      S_EVAL:   state_nxt = sts.ant_here ? S_RD_NEW : S_RESP;
      S_RD_NEW: state_nxt = S_MARK;
      S_MARK:   state_nxt = S_RESP;
      S_RESP:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clr_en = 1'b1;
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      S_EVAL:   cmd.eval     = 1'b1;
      S_RD_NEW: cmd.rd_new   = 1'b1;
      S_MARK:   cmd.mark     = 1'b1;
      S_RESP:   cmd.load_out = out_free;
      default:  cmd          = '0;
    endcase
  end

  assign out_tvalid_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  `LANT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second request taken early")
  `LANT_ASSERT_NEXT(a_load_shows, cmd.load_out, out_tvalid, "loaded result not presented")
  `LANT_ASSERT_NEXT(a_resp_waits, (state_r == S_RESP) && out_tvalid_r && !out_tready, state_r == S_RESP, "response left before output slot freed")

endmodule

`default_nettype wire
